// ----- sv/cwts_pkg.sv -----
`default_nettype none
package cwts_pkg;
    localparam int HISTORY_DEPTH_DEF  = 1024;
    localparam int RATE_FRAC_BITS_DEF = 15;
    localparam int CNT_W   = 11;
    localparam int RATE_W  = 16;
    localparam int ENTRY_W = 32 + 16 + 16 + 32 + 8 + 3;
    localparam int IN_W    = 112;
    localparam int OUT_W   = 152;
    localparam logic [1:0] REG_WINDOW_SECONDS = 2'd0;
    localparam logic [1:0] REG_RECENT_COUNT   = 2'd1;
    localparam logic [1:0] REG_OTHER_SERVICE  = 2'd2;
    localparam logic [2:0] FLAG_S0  = 3'd1;
    localparam logic [2:0] FLAG_S3  = 3'd4;
    localparam logic [2:0] FLAG_REJ = 3'd5;

    typedef struct packed {
        logic [31:0] dest_host;
        logic [15:0] dest_port;
        logic [15:0] src_port;
        logic [31:0] time_sec;
        logic [7:0]  service_code;
        logic [2:0]  flag_code;
    } rec_t;

    // one tally: eleven counters, each wide enough for the history depth
    typedef struct packed {
        logic [16:0] host_cnt;
        logic [16:0] port_cnt;
        logic [16:0] total;
        logic [16:0] serr;
        logic [16:0] rerr;
        logic [16:0] svc_same;
        logic [16:0] svc_diff;
        logic [16:0] p_serr;
        logic [16:0] p_rerr;
        logic [16:0] p_diff_host;
        logic [16:0] same_src;
    } tally_t;
endpackage
`default_nettype wire

// ----- sv/cwts_div.sv -----
`default_nettype none
// restoring divider: quotient of (num << FRAC) / den, one bit per cycle
module cwts_div #(
    parameter int FRAC  = cwts_pkg::RATE_FRAC_BITS_DEF,
    parameter int NUM_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  busy,
    output logic [15:0]           quo
);
    localparam int QW = NUM_W + FRAC;
    localparam int CW = $clog2(QW + 1);
    logic [QW-1:0]    dvd_reg;
    logic [QW-1:0]    q_reg;
    logic [NUM_W:0]   rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg[NUM_W-1:0], dvd_reg[QW-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {FRAC{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            if (!diff[NUM_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = (den_reg == '0) ? 16'd0 : q_reg[15:0];
endmodule
`default_nettype wire

// ----- sv/cwts_hist.sv -----
`default_nettype none
// history ring: one write port, one registered read port
module cwts_hist #(
    parameter int DEPTH = cwts_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire cwts_pkg::rec_t wdata,
    input  wire logic [AW-1:0] raddr,
    output cwts_pkg::rec_t      rdata
);
    cwts_pkg::rec_t mem [DEPTH];
    cwts_pkg::rec_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;
endmodule
`default_nettype wire

// ----- sv/connection_window_traffic_stats.sv -----
`default_nettype none
// Connection window traffic statistics.
// s_axis: one connection record per transfer (tdata below). m_axis: two result
// transfers per record, the time window result first (tuser = 0), then the
// count window result (tuser = 1, tlast = 1). cfg: register writes by index
// (0 window_seconds, 1 recent_count, 2 other_service_code); write only while idle.
// Each record is compared with up to HISTORY_DEPTH earlier records held in a
// history memory with one registered read port, one entry per cycle. Rates
// then come from one shared bit-serial divider: a start step, one shift step
// per quotient bit and a hand-off step for each rate, eight rates per result and
// sixteen per record.
// The record is written into the ring at the end of its scan.
// Reset clears control state, fill count and write pointer; the memory contents
// are never cleared since only written entries are read.
// A stalled m_axis receiver holds the result register; the block does not
// take the next record until both results have been transferred.
module connection_window_traffic_stats #(
    parameter int HISTORY_DEPTH  = cwts_pkg::HISTORY_DEPTH_DEF,
    parameter int RATE_FRAC_BITS = cwts_pkg::RATE_FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // dest_host[31:0], dest_port[47:32], src_port[63:48], time_sec[95:64],
    // service_code[103:96], flag_code[106:104], zero fill
    input  wire logic [cwts_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // host_count[10:0], port_count[21:11], syn_error_rate, port_syn_error_rate,
    // reject_rate, port_reject_rate, same_service_rate, diff_service_rate,
    // port_diff_host_rate, src_port_match_rate (16 bits each from bit 22), zero fill
    output logic [cwts_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tuser,  // window_kind
    output logic                       m_axis_tlast,  // last
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [10:0]           cfg_data
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = AW + 1;
    localparam int CW = 17;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic [7:0]  win_reg;
    logic [10:0] recent_reg;
    logic [7:0]  other_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    cwts_pkg::rec_t cur_reg;
    logic [FW-1:0] k_reg;      // reads issued
    logic [FW-1:0] n_reg;      // entries to scan
    logic          rv_reg;     // read data valid
    logic [FW-1:0] rk_reg;     // age of entry in read data
    cwts_pkg::tally_t tw_reg, tc_reg;
    logic [3:0]  di_reg;
    logic        ph_reg;       // 0 time result, 1 count result
    logic [15:0] rates_reg [8];

    cwts_pkg::rec_t rd;
    cwts_pkg::rec_t in_rec;
    logic [AW-1:0] raddr;
    logic          in_acc;

    assign in_rec = cwts_pkg::rec_t'({s_axis_tdata[31:0], s_axis_tdata[47:32],
        s_axis_tdata[63:48], s_axis_tdata[95:64], s_axis_tdata[103:96],
        s_axis_tdata[106:104]});
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign raddr = wp_reg - AW'(1) - k_reg[AW-1:0];

    cwts_hist #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
        .clk(clk), .we(state_reg == ST_SCAN && k_reg == n_reg && !rv_reg),
        .waddr(wp_reg), .wdata(cur_reg), .raddr(raddr), .rdata(rd));

    // per-entry match logic
    logic h_eq, p_eq, s_eq, syn, rej, in_time, in_cnt;
    logic [32:0] tsum;
    always_comb
    begin
        h_eq = rd.dest_host == cur_reg.dest_host;
        p_eq = rd.dest_port == cur_reg.dest_port;
        s_eq = rd.src_port == cur_reg.src_port;
        syn  = rd.flag_code >= cwts_pkg::FLAG_S0 && rd.flag_code <= cwts_pkg::FLAG_S3;
        rej  = rd.flag_code == cwts_pkg::FLAG_REJ;
        tsum = {1'b0, rd.time_sec} + 33'(win_reg);
        in_time = rd.time_sec <= cur_reg.time_sec && tsum >= {1'b0, cur_reg.time_sec};
        in_cnt  = 32'(rk_reg) < 32'(recent_reg);
    end

    function automatic cwts_pkg::tally_t upd(cwts_pkg::tally_t t, logic h, logic p,
        logic s, logic sy, logic rj, logic ss, logic ds, logic ph);
        cwts_pkg::tally_t r;
        r = t;
        r.total = t.total + 1'b1;
        if (h)
        begin
            r.host_cnt = t.host_cnt + 1'b1;
            r.serr = t.serr + CW'(sy);
            r.rerr = t.rerr + CW'(rj);
            r.svc_same = t.svc_same + CW'(ss);
            r.svc_diff = t.svc_diff + CW'(ds);
        end
        if (p)
        begin
            r.port_cnt = t.port_cnt + 1'b1;
            r.p_serr = t.p_serr + CW'(sy);
            r.p_rerr = t.p_rerr + CW'(rj);
            r.p_diff_host = t.p_diff_host + CW'(ph);
        end
        if (s)
            r.same_src = t.same_src + 1'b1;
        return r;
    endfunction

    logic ss_m, ds_m;
    assign ss_m = rd.service_code != other_reg && rd.service_code == cur_reg.service_code;
    assign ds_m = rd.service_code != cur_reg.service_code;

    // divider operand selection
    cwts_pkg::tally_t ts;
    logic [CW-1:0] dnum, dden;
    logic [15:0] dq;
    logic dbusy, dstart;
    always_comb
    begin
        ts = ph_reg ? tc_reg : tw_reg;
        case (di_reg)
            4'd0: begin dnum = ts.serr;        dden = ts.host_cnt; end
            4'd1: begin dnum = ts.p_serr;      dden = ts.port_cnt; end
            4'd2: begin dnum = ts.rerr;        dden = ts.host_cnt; end
            4'd3: begin dnum = ts.p_rerr;      dden = ts.port_cnt; end
            4'd4: begin dnum = ts.svc_same;    dden = ts.host_cnt; end
            4'd5: begin dnum = ts.svc_diff;    dden = ts.host_cnt; end
            4'd6: begin dnum = ts.p_diff_host; dden = ts.port_cnt; end
            4'd7: begin dnum = ts.same_src;    dden = ph_reg ? ts.total : '0; end
            default: begin dnum = '0;          dden = '0; end
        endcase
    end
    assign dstart = state_reg == ST_DIV;

    cwts_div #(.FRAC(RATE_FRAC_BITS), .NUM_W(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quo(dq));

    logic [FW-1:0] nmin;
    assign nmin = fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            win_reg    <= 8'd2;
            recent_reg <= 11'd100;
            other_reg  <= 8'd0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    cwts_pkg::REG_WINDOW_SECONDS: win_reg <= cfg_data[7:0];
                    cwts_pkg::REG_RECENT_COUNT:   recent_reg <= cfg_data;
                    cwts_pkg::REG_OTHER_SERVICE:  other_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        state_reg <= ST_SCAN;
                        rv_reg <= 1'b0;
                    end
                ST_SCAN:
                begin
                    rv_reg <= k_reg != n_reg;
                    if (k_reg == n_reg && !rv_reg)
                    begin
                        wp_reg <= wp_reg + 1'b1;
                        if (fill_reg != FW'(HISTORY_DEPTH))
                            fill_reg <= fill_reg + 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:  state_reg <= ST_WAIT;
                ST_WAIT:
                    if (!dbusy)
                        state_reg <= (di_reg == 4'd7) ? ST_OUT : ST_DIV;
                ST_OUT:
                    if (m_axis_tready)
                        state_reg <= ph_reg ? ST_IDLE : ST_DIV;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= in_rec;
                k_reg <= '0;
                n_reg <= nmin;
                tw_reg <= '0;
                tc_reg <= '0;
                di_reg <= '0;
                ph_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                if (k_reg != n_reg)
                    k_reg <= k_reg + 1'b1;
                rk_reg <= k_reg;
                if (rv_reg)
                begin
                    if (in_time)
                        tw_reg <= upd(tw_reg, h_eq, p_eq, s_eq, syn, rej, ss_m, ds_m, !h_eq);
                    if (in_cnt)
                        tc_reg <= upd(tc_reg, h_eq, p_eq, s_eq, syn, rej, ss_m, ds_m, !h_eq);
                end
            end
            ST_WAIT:
                if (!dbusy)
                begin
                    rates_reg[di_reg[2:0]] <= dq;
                    if (di_reg != 4'd7)
                        di_reg <= di_reg + 1'b1;
                end
            ST_OUT:
                if (m_axis_tready)
                begin
                    ph_reg <= 1'b1;
                    di_reg <= '0;
                end
            default: ;
        endcase
    end

    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tuser  = ph_reg;
    assign m_axis_tlast  = ph_reg;
    assign m_axis_tdata  = {2'd0, rates_reg[7], rates_reg[6], rates_reg[5], rates_reg[4],
        rates_reg[3], rates_reg[2], rates_reg[1], rates_reg[0],
        ts.port_cnt[10:0], ts.host_cnt[10:0]};
endmodule
`default_nettype wire

// ----- sv/cwts_checker.sv -----
`default_nettype none
module cwts_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tuser,
    input wire logic m_axis_tlast
);
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast == m_axis_tuser) else $error("tlast/tuser");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result dropped");
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind connection_window_traffic_stats cwts_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast));
`default_nettype wire
